// ===== hw/rtl/eapm_pkg.sv =====
// Shared constants, register codes, types and helpers for the ellipse arc point map.
package eapm_pkg;

   // Default build settings
   localparam int DEF_CORDIC_STAGES = 16;
   localparam int DEF_FRAC_BITS     = 16;
   localparam int ATAN_ENTRIES      = 30;

   // Field widths
   localparam int PARAM_W    = 17;
   localparam int COORD_W    = 32;
   localparam int COORD_FRAC = 16;
   localparam int TURN_W     = 24;
   localparam int SPAN_W     = TURN_W + 1;
   localparam int PHASE_W    = 32;
   localparam int OMEGA_W    = 28;   // 2*pi*span, Q.16 radians
   localparam int DIMS_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int WIDE_W     = 48;   // headroom ahead of saturation

   // Arithmetic constants
   localparam longint                 GAIN_Q30   = 64'sd652032874;
   localparam logic signed [32:0]     TWO_PI_Q29 = 33'sd3373259426;
   localparam int                     OMEGA_LSB  = 29;
   localparam logic [PARAM_W-1:0]     PARAM_ONE  = 17'd65536;
   localparam logic signed [31:0]     AXIS_ONE   = 32'sd65536;
   localparam logic [PHASE_W-1:0]     HALF_QUAD  = 32'h2000_0000;
   localparam logic signed [WIDE_W-1:0] SAT_MAX  = 48'sh0000_7FFF_FFFF;
   localparam logic signed [WIDE_W-1:0] SAT_MIN  = -48'sh0000_8000_0000;
   localparam logic [DIMS_W-1:0]      DIMS_3D    = 2'd3;

   // Register reset values
   localparam logic signed [COORD_W-1:0] RST_SEMI_AXIS = 32'sd65536;
   localparam logic signed [COORD_W-1:0] RST_CENTRE    = 32'sd0;
   localparam logic signed [TURN_W-1:0]  RST_START     = 24'sd0;
   localparam logic signed [TURN_W-1:0]  RST_END       = 24'sd65536;
   localparam logic [DIMS_W-1:0]         RST_DIMS      = 2'd2;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
      32'd20,        32'd10,        32'd5,         32'd3,        32'd1
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEMI_AXIS_X = 3'd0,
      CSR_SEMI_AXIS_Y = 3'd1,
      CSR_CENTRE_X    = 3'd2,
      CSR_CENTRE_Y    = 3'd3,
      CSR_CENTRE_Z    = 3'd4,
      CSR_START_TURNS = 3'd5,
      CSR_END_TURNS   = 3'd6,
      CSR_RANGE_DIMS  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quadrant_type;

   // Rounded CORDIC gain at the given fraction width
   function automatic longint cordic_x0(input int frac_bits);
      return (GAIN_Q30 + (longint'(1) <<< (29 - frac_bits))) >>> (30 - frac_bits);
   endfunction

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[COORD_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/eapm_front.sv =====
// Phase stage: clamps r, forms the phase and splits it into quadrant and residual.
module eapm_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [eapm_pkg::PARAM_W-1:0]         param_r,
   input  logic signed [eapm_pkg::TURN_W-1:0]   start_turns,
   input  logic signed [eapm_pkg::SPAN_W-1:0]   span,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [eapm_pkg::PHASE_W-1:0]  out_z,
   output eapm_pkg::quadrant_type               out_q
);

   localparam int PROD_W = eapm_pkg::SPAN_W + eapm_pkg::PARAM_W + 1;

   logic                               valid_ff, valid_in;
   logic [eapm_pkg::PHASE_W-1:0]       phase_ff, phase_in;
   logic [eapm_pkg::PARAM_W-1:0]       r_clamp;
   logic signed [PROD_W-1:0]           prod;
   logic [eapm_pkg::PHASE_W-1:0]       rounded;

   assign in_ready = !valid_ff || out_ready;
   assign r_clamp  = (param_r > eapm_pkg::PARAM_ONE) ? eapm_pkg::PARAM_ONE : param_r;
   assign prod     = span * $signed({1'b0, r_clamp});
   // start << 16 plus span * r, modulo one turn
   assign phase_in = {start_turns[15:0], 16'h0000} + prod[eapm_pkg::PHASE_W-1:0];
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         phase_ff <= phase_in;
      end
   end

   // nearest quarter turn; residual in [-1/8, 1/8) turn
   assign rounded   = phase_ff + eapm_pkg::HALF_QUAD;
   assign out_q     = eapm_pkg::quadrant_type'(rounded[31:30]);
   assign out_z     = $signed({2'b00, rounded[29:0]}) - $signed(eapm_pkg::HALF_QUAD);
   assign out_valid = valid_ff;

endmodule

// ===== hw/rtl/eapm_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation with its own pipeline register.
module eapm_cell #(
   parameter int XW    = eapm_pkg::DEF_FRAC_BITS + 3,
   parameter int STAGE = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [XW-1:0]                 in_x,
   input  logic signed [XW-1:0]                 in_y,
   input  logic signed [eapm_pkg::PHASE_W-1:0]  in_z,
   input  eapm_pkg::quadrant_type               in_q,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [XW-1:0]                 out_x,
   output logic signed [XW-1:0]                 out_y,
   output logic signed [eapm_pkg::PHASE_W-1:0]  out_z,
   output eapm_pkg::quadrant_type               out_q
);

   localparam logic signed [eapm_pkg::PHASE_W-1:0] ANGLE =
      $signed(eapm_pkg::ATAN_TURNS[STAGE]);

   logic                                valid_ff, valid_in;
   logic signed [XW-1:0]                x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [eapm_pkg::PHASE_W-1:0] z_ff, z_in;
   eapm_pkg::quadrant_type              q_ff;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign dx = in_y >>> STAGE;
   assign dy = in_x >>> STAGE;

   // zero residual rotates forward
   always_comb begin
      if (!in_z[eapm_pkg::PHASE_W-1]) begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ANGLE;
      end else begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         q_ff <= in_q;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_q     = q_ff;

endmodule

// ===== hw/rtl/eapm_back.sv =====
// Output stages: quadrant rotation, axis scaling, slopes, centre offset, saturation.
module eapm_back #(
   parameter int FRAC_BITS = eapm_pkg::DEF_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [FRAC_BITS+2:0]          in_x,
   input  logic signed [FRAC_BITS+2:0]          in_y,
   input  eapm_pkg::quadrant_type               in_q,
   input  logic signed [eapm_pkg::COORD_W-1:0]  axis_a,
   input  logic signed [eapm_pkg::COORD_W-1:0]  axis_b,
   input  logic signed [eapm_pkg::COORD_W-1:0]  centre_x,
   input  logic signed [eapm_pkg::COORD_W-1:0]  centre_y,
   input  logic signed [eapm_pkg::COORD_W-1:0]  centre_z,
   input  logic [eapm_pkg::DIMS_W-1:0]          range_dims,
   input  logic signed [eapm_pkg::OMEGA_W-1:0]  omega,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [eapm_pkg::COORD_W-1:0]  point_x,
   output logic signed [eapm_pkg::COORD_W-1:0]  point_y,
   output logic signed [eapm_pkg::COORD_W-1:0]  point_z,
   output logic signed [eapm_pkg::COORD_W-1:0]  slope_x,
   output logic signed [eapm_pkg::COORD_W-1:0]  slope_y
);

   localparam int XW   = FRAC_BITS + 3;
   localparam int AC_W = eapm_pkg::COORD_W + XW;
   localparam int WS_W = eapm_pkg::OMEGA_W + XW;
   localparam int U_W  = WS_W - FRAC_BITS;
   localparam int SL_W = eapm_pkg::COORD_W + U_W;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic rdy2, rdy3;

   logic signed [XW-1:0]   cos_v, sin_v;
   logic signed [AC_W-1:0] ac_ff, ac_in, bs_ff, bs_in;
   logic signed [WS_W-1:0] ws_ff, ws_in, wc_ff, wc_in;

   logic signed [U_W-1:0]  ux, uy;
   logic signed [SL_W-1:0] ax_ff, ax_in, by_ff, by_in;
   logic signed [eapm_pkg::COORD_W-1:0] px_ff, px_in, py_ff, py_in;

   logic signed [eapm_pkg::COORD_W-1:0] point_x_ff, point_y_ff, point_z_ff, point_z_in;
   logic signed [eapm_pkg::COORD_W-1:0] slope_x_ff, slope_x_in, slope_y_ff, slope_y_in;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign in_ready = !v1_ff || rdy2;
   assign v1_in    = in_ready ? in_valid : v1_ff;
   assign v2_in    = rdy2 ? v1_ff : v2_ff;
   assign v3_in    = rdy3 ? v2_ff : v3_ff;

   // undo the quadrant reduction
   always_comb begin
      unique case (in_q)
         eapm_pkg::QUAD_0: begin
            cos_v = in_x;
            sin_v = in_y;
         end
         eapm_pkg::QUAD_1: begin
            cos_v = -in_y;
            sin_v = in_x;
         end
         eapm_pkg::QUAD_2: begin
            cos_v = -in_x;
            sin_v = -in_y;
         end
         eapm_pkg::QUAD_3: begin
            cos_v = in_y;
            sin_v = -in_x;
         end
      endcase
   end

   // stage 1: products with the trig values
   assign ac_in = axis_a * cos_v;
   assign bs_in = axis_b * sin_v;
   assign ws_in = omega * sin_v;
   assign wc_in = omega * cos_v;

   // stage 2: points done, slope products started
   assign px_in = eapm_pkg::sat32(
      eapm_pkg::WIDE_W'($signed(ac_ff[AC_W-1:FRAC_BITS])) +
      eapm_pkg::WIDE_W'(centre_x));
   assign py_in = eapm_pkg::sat32(
      eapm_pkg::WIDE_W'($signed(bs_ff[AC_W-1:FRAC_BITS])) +
      eapm_pkg::WIDE_W'(centre_y));
   assign ux    = $signed(ws_ff[WS_W-1:FRAC_BITS]);
   assign uy    = $signed(wc_ff[WS_W-1:FRAC_BITS]);
   assign ax_in = axis_a * ux;
   assign by_in = axis_b * uy;

   // stage 3: slope scaling and saturation
   assign slope_x_in = eapm_pkg::sat32(
      -eapm_pkg::WIDE_W'($signed(ax_ff[SL_W-1:eapm_pkg::COORD_FRAC])));
   assign slope_y_in = eapm_pkg::sat32(
      eapm_pkg::WIDE_W'($signed(by_ff[SL_W-1:eapm_pkg::COORD_FRAC])));
   assign point_z_in = (range_dims == eapm_pkg::DIMS_3D) ? centre_z : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      if (in_ready && in_valid) begin
         ac_ff <= ac_in;
         bs_ff <= bs_in;
         ws_ff <= ws_in;
         wc_ff <= wc_in;
      end
      if (rdy2 && v1_ff) begin
         px_ff <= px_in;
         py_ff <= py_in;
         ax_ff <= ax_in;
         by_ff <= by_in;
      end
      if (rdy3 && v2_ff) begin
         point_x_ff <= px_ff;
         point_y_ff <= py_ff;
         point_z_ff <= point_z_in;
         slope_x_ff <= slope_x_in;
         slope_y_ff <= slope_y_in;
      end
   end

   assign out_valid = v3_ff;
   assign point_x   = point_x_ff;
   assign point_y   = point_y_ff;
   assign point_z   = point_z_ff;
   assign slope_x   = slope_x_ff;
   assign slope_y   = slope_y_ff;

endmodule

// ===== hw/rtl/ellipse_arc_point_map.sv =====
// Ellipse arc point map: top level with configuration registers and the CORDIC cell row.
// Throughput: one transaction per cycle while rsp_stall is low, set by the fully
//   pipelined row of CORDIC cells. A request passes the phase stage, the cells and
//   three output stages before its response is valid; only rsp_stall can hold it back.
// Each stage holds its own valid bit, so bubbles collapse and requests keep flowing
//   while a finished response waits.
// Reset (synchronous): empties the pipeline and loads the register reset values.
module ellipse_arc_point_map #(
   parameter int CORDIC_STAGES = eapm_pkg::DEF_CORDIC_STAGES,
   parameter int FRAC_BITS     = eapm_pkg::DEF_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [eapm_pkg::PARAM_W-1:0]          req_param_r,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [eapm_pkg::COORD_W-1:0]   rsp_point_x,
   output logic signed [eapm_pkg::COORD_W-1:0]   rsp_point_y,
   output logic signed [eapm_pkg::COORD_W-1:0]   rsp_point_z,
   output logic signed [eapm_pkg::COORD_W-1:0]   rsp_slope_x,
   output logic signed [eapm_pkg::COORD_W-1:0]   rsp_slope_y,
   // configuration write port
   input  logic                                  csr_we,
   input  logic [eapm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [eapm_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int XW = FRAC_BITS + 3;   // sign, integer bit and CORDIC growth headroom
   localparam logic signed [XW-1:0] CORDIC_X0 = XW'(eapm_pkg::cordic_x0(FRAC_BITS));
   localparam int OMEGA_PROD_W = eapm_pkg::SPAN_W + 33;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic signed [eapm_pkg::COORD_W-1:0] semi_axis_x_ff, semi_axis_y_ff;
   logic signed [eapm_pkg::COORD_W-1:0] centre_x_ff, centre_y_ff, centre_z_ff;
   logic signed [eapm_pkg::TURN_W-1:0]  start_turns_ff, end_turns_ff;
   logic [eapm_pkg::DIMS_W-1:0]         range_dims_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         semi_axis_x_ff <= eapm_pkg::RST_SEMI_AXIS;
         semi_axis_y_ff <= eapm_pkg::RST_SEMI_AXIS;
         centre_x_ff    <= eapm_pkg::RST_CENTRE;
         centre_y_ff    <= eapm_pkg::RST_CENTRE;
         centre_z_ff    <= eapm_pkg::RST_CENTRE;
         start_turns_ff <= eapm_pkg::RST_START;
         end_turns_ff   <= eapm_pkg::RST_END;
         range_dims_ff  <= eapm_pkg::RST_DIMS;
      end else if (csr_we) begin
         // upper data bits beyond a register's width are dropped
         unique case (eapm_pkg::csr_index_type'(csr_index))
            eapm_pkg::CSR_SEMI_AXIS_X: semi_axis_x_ff <= $signed(csr_wdata);
            eapm_pkg::CSR_SEMI_AXIS_Y: semi_axis_y_ff <= $signed(csr_wdata);
            eapm_pkg::CSR_CENTRE_X:    centre_x_ff    <= $signed(csr_wdata);
            eapm_pkg::CSR_CENTRE_Y:    centre_y_ff    <= $signed(csr_wdata);
            eapm_pkg::CSR_CENTRE_Z:    centre_z_ff    <= $signed(csr_wdata);
            eapm_pkg::CSR_START_TURNS:
               start_turns_ff <= $signed(csr_wdata[eapm_pkg::TURN_W-1:0]);
            eapm_pkg::CSR_END_TURNS:
               end_turns_ff   <= $signed(csr_wdata[eapm_pkg::TURN_W-1:0]);
            eapm_pkg::CSR_RANGE_DIMS:
               range_dims_ff  <= csr_wdata[eapm_pkg::DIMS_W-1:0];
         endcase
      end
   end

   // Derived settings. A zero axis behaves as 1.0.
   logic signed [eapm_pkg::COORD_W-1:0] axis_a, axis_b;
   logic signed [eapm_pkg::SPAN_W-1:0]  span;
   logic signed [OMEGA_PROD_W-1:0]      omega_prod;
   logic signed [eapm_pkg::OMEGA_W-1:0] omega_ff, omega_in;

   assign axis_a = (semi_axis_x_ff == '0) ? eapm_pkg::AXIS_ONE : semi_axis_x_ff;
   assign axis_b = (semi_axis_y_ff == '0) ? eapm_pkg::AXIS_ONE : semi_axis_y_ff;
   assign span   = eapm_pkg::SPAN_W'(end_turns_ff) - eapm_pkg::SPAN_W'(start_turns_ff);

   // omega = floor(2*pi * span), Q.16 radians per unit r. Registered straight
   // off the config; it is consumed only after the cell row, long after any write.
   assign omega_prod = span * eapm_pkg::TWO_PI_Q29;
   assign omega_in   = $signed(omega_prod[eapm_pkg::OMEGA_LSB + eapm_pkg::OMEGA_W - 1 :
                                          eapm_pkg::OMEGA_LSB]);

   always_ff @(posedge clock) begin
      omega_ff <= omega_in;
   end

   // ---------------------------------------------------------------------
   // Phase stage
   // ---------------------------------------------------------------------
   logic                                 valid_bus [CORDIC_STAGES+1];
   logic                                 ready_bus [CORDIC_STAGES+1];
   logic signed [XW-1:0]                 x_bus     [CORDIC_STAGES+1];
   logic signed [XW-1:0]                 y_bus     [CORDIC_STAGES+1];
   logic signed [eapm_pkg::PHASE_W-1:0]  z_bus     [CORDIC_STAGES+1];
   eapm_pkg::quadrant_type               q_bus     [CORDIC_STAGES+1];
   logic                                 req_ready, rsp_ready;

   assign req_stall = !req_ready;
   assign rsp_ready = !rsp_stall;

   eapm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .param_r     (req_param_r),
      .start_turns (start_turns_ff),
      .span        (span),
      .out_valid   (valid_bus[0]),
      .out_ready   (ready_bus[0]),
      .out_z       (z_bus[0]),
      .out_q       (q_bus[0])
   );

   // CORDIC starts from the gain-compensated unit vector
   assign x_bus[0] = CORDIC_X0;
   assign y_bus[0] = '0;

   // ---------------------------------------------------------------------
   // Row of CORDIC cells, one micro-rotation each
   // ---------------------------------------------------------------------
   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
      eapm_cell #(
         .XW    (XW),
         .STAGE (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_bus[k]),
         .in_ready  (ready_bus[k]),
         .in_x      (x_bus[k]),
         .in_y      (y_bus[k]),
         .in_z      (z_bus[k]),
         .in_q      (q_bus[k]),
         .out_valid (valid_bus[k+1]),
         .out_ready (ready_bus[k+1]),
         .out_x     (x_bus[k+1]),
         .out_y     (y_bus[k+1]),
         .out_z     (z_bus[k+1]),
         .out_q     (q_bus[k+1])
      );
   end

   // ---------------------------------------------------------------------
   // Output stages; the residual angle is spent and dropped here
   // ---------------------------------------------------------------------
   logic [eapm_pkg::PHASE_W-1:0] z_spent;
   assign z_spent = z_bus[CORDIC_STAGES];

   eapm_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (valid_bus[CORDIC_STAGES] && (z_spent == z_spent)),
      .in_ready   (ready_bus[CORDIC_STAGES]),
      .in_x       (x_bus[CORDIC_STAGES]),
      .in_y       (y_bus[CORDIC_STAGES]),
      .in_q       (q_bus[CORDIC_STAGES]),
      .axis_a     (axis_a),
      .axis_b     (axis_b),
      .centre_x   (centre_x_ff),
      .centre_y   (centre_y_ff),
      .centre_z   (centre_z_ff),
      .range_dims (range_dims_ff),
      .omega      (omega_ff),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .point_x    (rsp_point_x),
      .point_y    (rsp_point_y),
      .point_z    (rsp_point_z),
      .slope_x    (rsp_slope_x),
      .slope_y    (rsp_slope_y)
   );

endmodule

// ===== hw/rtl/eapm_checker.sv =====
// Port-level checks for the ellipse arc point map, bound to the top level.
module eapm_checker #(
   parameter int LATENCY = eapm_pkg::DEF_CORDIC_STAGES + 4
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [eapm_pkg::PARAM_W-1:0]         req_param_r,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [eapm_pkg::COORD_W-1:0]  rsp_point_x,
   input logic signed [eapm_pkg::COORD_W-1:0]  rsp_point_y,
   input logic signed [eapm_pkg::COORD_W-1:0]  rsp_point_z,
   input logic signed [eapm_pkg::COORD_W-1:0]  rsp_slope_x,
   input logic signed [eapm_pkg::COORD_W-1:0]  rsp_slope_y
);

   // no response can reach the port sooner than the pipeline depth after reset
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      $past(reset, LATENCY) |-> !rsp_valid)
      else $error("response appeared sooner than pipeline latency after reset");

   // an open response side must never back-pressure requests
   a_open_flow: assert property (@(posedge clock)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is open");

   // a stalled request transaction stays put
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_param_r))
      else $error("stalled request changed");

   // a stalled response transaction stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point_x) &&
         $stable(rsp_point_y) && $stable(rsp_point_z) &&
         $stable(rsp_slope_x) && $stable(rsp_slope_y))
      else $error("stalled response changed");

endmodule

bind ellipse_arc_point_map eapm_checker #(
   .LATENCY (CORDIC_STAGES + 4)
) u_eapm_checker (.*);

// ===== bench/tb_ellipse_arc_point_map.sv =====
// Testbench for the ellipse arc point map: scoreboard, stimulus and handshake timing.
`timescale 1ns / 1ps

module tb_ellipse_arc_point_map;

   // Request to response latency at the default build (phase, 16 cells, 3 output stages)
   localparam int      PIPE_LATENCY = 20;
   localparam int      HOLD_CYCLES  = 150;      // long receiver hold-off for the pressure test
   localparam int      CYCLE_LIMIT  = 200000;   // watchdog, far above a slow passing run
   localparam int      IDLE_PCT     = 29;
   localparam int      CORDIC_STEPS = 16;
   localparam int      FRAC         = 16;
   localparam longint  PARAM_MAX    = 65536;    // 1.0 in Q1.16
   localparam longint  AXIS_UNIT    = 65536;    // a zero axis stands for 1.0
   localparam longint  TAU_Q29      = 64'sd3373259426;
   localparam longint  GAIN_START   = (64'sd652032874 + 64'sd8192) >>> 14;
   localparam longint  SAT_HI       = 64'sd2147483647;
   localparam longint  SAT_LO       = -64'sd2147483648;
   localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;
   localparam logic [1:0]  DIMS_XYZ    = 2'd3;

   // atan(2^-i), units of 2^-32 turn
   localparam longint ARC_ATAN [0:15] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861
   };

   // Shadow copy of the register file, already trimmed to register widths
   typedef struct packed {
      logic signed [31:0] axis_x;
      logic signed [31:0] axis_y;
      logic signed [31:0] centre_x;
      logic signed [31:0] centre_y;
      logic signed [31:0] centre_z;
      logic signed [23:0] start_turns;
      logic signed [23:0] stop_turns;
      logic [1:0]         dims;
   } arc_cfg_type;

   // One expected response transaction
   typedef struct packed {
      logic [31:0] point_x;
      logic [31:0] point_y;
      logic [31:0] point_z;
      logic [31:0] slope_x;
      logic [31:0] slope_y;
   } arc_point_type;

   // Raw write data for registers 0..7, index 0 leftmost
   typedef logic [0:7][31:0] reg_words_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid   = 1'b0;
   logic                                req_stall;
   logic [eapm_pkg::PARAM_W-1:0]        req_param_r = '0;
   logic                                rsp_valid;
   logic                                rsp_stall   = 1'b0;
   logic signed [eapm_pkg::COORD_W-1:0] rsp_point_x;
   logic signed [eapm_pkg::COORD_W-1:0] rsp_point_y;
   logic signed [eapm_pkg::COORD_W-1:0] rsp_point_z;
   logic signed [eapm_pkg::COORD_W-1:0] rsp_slope_x;
   logic signed [eapm_pkg::COORD_W-1:0] rsp_slope_y;
   logic                                csr_we      = 1'b0;
   eapm_pkg::csr_index_type             csr_index   = eapm_pkg::CSR_SEMI_AXIS_X;
   logic [eapm_pkg::CSR_DATA_W-1:0]     csr_wdata   = '0;

   arc_cfg_type   arc_regs = '{32'sd65536, 32'sd65536, 32'sd0, 32'sd0, 32'sd0,
                               24'sd0, 24'sd65536, 2'd2};
   arc_point_type pending_points [$];
   int            mismatch_count = 0;
   int            cycle_count    = 0;
   int            gap_pct        = IDLE_PCT;   // idle chance per cycle, both sides
   int            hold_ask       = 0;          // bumped to request one long hold-off

   ellipse_arc_point_map dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_param_r (req_param_r),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_point_x (rsp_point_x),
      .rsp_point_y (rsp_point_y),
      .rsp_point_z (rsp_point_z),
      .rsp_slope_x (rsp_slope_x),
      .rsp_slope_y (rsp_slope_y),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   function automatic logic [31:0] clip32(input longint v);
      logic [31:0] r;
      if (v > SAT_HI) begin
         r = 32'h7FFF_FFFF;
      end else if (v < SAT_LO) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Point and slope on the arc for one parameter under the given registers
   function automatic arc_point_type predict_arc_point(input arc_cfg_type c,
                                                       input logic [eapm_pkg::PARAM_W-1:0] r);
      longint                 a, b, span, rr, x, y, z, dx, dy, cs, sn, w, ux, uy;
      logic [31:0]            phase, resid;
      eapm_pkg::quadrant_type quad;
      arc_point_type          p;
      a    = (c.axis_x == 0) ? AXIS_UNIT : longint'($signed(c.axis_x));
      b    = (c.axis_y == 0) ? AXIS_UNIT : longint'($signed(c.axis_y));
      span = longint'($signed(c.stop_turns)) - longint'($signed(c.start_turns));
      rr   = (longint'(r) > PARAM_MAX) ? PARAM_MAX : longint'(r);

      // phase in 2^-32 turn, wraps mod one turn
      phase = 32'((longint'($signed(c.start_turns)) <<< 16) + span * rr);

      // split into nearest quarter turn and a residual within +/- 1/8 turn
      quad  = eapm_pkg::quadrant_type'(2'((phase + EIGHTH_TURN) >> 30));
      resid = phase - {quad, 30'd0};
      z     = longint'($signed(resid));
      x     = GAIN_START;
      y     = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ARC_ATAN[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ARC_ATAN[i];
         end
      end
      case (quad)
         eapm_pkg::QUAD_0: begin cs = x;  sn = y;  end
         eapm_pkg::QUAD_1: begin cs = -y; sn = x;  end
         eapm_pkg::QUAD_2: begin cs = -x; sn = -y; end
         default:          begin cs = y;  sn = -x; end
      endcase

      // d(theta)/dr = 2*pi*span, Q.16 radians
      w  = (span * TAU_Q29) >>> 29;
      ux = (w * sn) >>> FRAC;
      uy = (w * cs) >>> FRAC;

      p.point_x = clip32(((a * cs) >>> FRAC) + longint'($signed(c.centre_x)));
      p.point_y = clip32(((b * sn) >>> FRAC) + longint'($signed(c.centre_y)));
      p.point_z = (c.dims == DIMS_XYZ) ? c.centre_z : 32'h0;
      p.slope_x = clip32(-((a * ux) >>> 16));
      p.slope_y = clip32((b * uy) >>> 16);
      return p;
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      $display("%0t MISMATCH %s", $time, msg);
      mismatch_count++;
   endtask

   // Every accepted response is matched against the oldest prediction
   always @(posedge clock) begin : check_arc_points
      arc_point_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_points.size() == 0) begin
            report_mismatch($sformatf("response with nothing pending, point_x %h",
                                      rsp_point_x));
         end else begin
            want = pending_points.pop_front();
            if (rsp_point_x !== want.point_x)
               report_mismatch($sformatf("point_x expected %h got %h",
                                         want.point_x, rsp_point_x));
            if (rsp_point_y !== want.point_y)
               report_mismatch($sformatf("point_y expected %h got %h",
                                         want.point_y, rsp_point_y));
            if (rsp_point_z !== want.point_z)
               report_mismatch($sformatf("point_z expected %h got %h",
                                         want.point_z, rsp_point_z));
            if (rsp_slope_x !== want.slope_x)
               report_mismatch($sformatf("slope_x expected %h got %h",
                                         want.slope_x, rsp_slope_x));
            if (rsp_slope_y !== want.slope_y)
               report_mismatch($sformatf("slope_y expected %h got %h",
                                         want.slope_y, rsp_slope_y));
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever hold_ask moves.
   // The hold is counted here so the sender keeps pushing until the block backs up.
   always @(posedge clock) begin : drive_rsp_stall
      int hold_left;
      int hold_seen;
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (hold_ask != hold_seen) begin
         hold_seen = hold_ask;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (gap_pct != 0) && ($urandom_range(99) < gap_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Offer one request transaction; returns at the edge that accepts it.
   // Valid is left high so the next call can follow back to back.
   task automatic send_param(input logic [eapm_pkg::PARAM_W-1:0] r);
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_param_r <= r;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      pending_points.push_back(predict_arc_point(arc_regs, r));
   endtask

   // Drop valid, drain every outstanding response, then let the pipe empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   // Write all eight registers with the block idle and track them in the shadow copy
   task automatic apply_config(input reg_words_type words);
      eapm_pkg::csr_index_type idx;
      wait_idle();
      for (int i = 0; i < 8; i++) begin
         idx = eapm_pkg::csr_index_type'(i);
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= words[i];
         @(posedge clock);
         // bits above a register's width are dropped by the block
         case (idx)
            eapm_pkg::CSR_SEMI_AXIS_X: arc_regs.axis_x      = words[i];
            eapm_pkg::CSR_SEMI_AXIS_Y: arc_regs.axis_y      = words[i];
            eapm_pkg::CSR_CENTRE_X:    arc_regs.centre_x    = words[i];
            eapm_pkg::CSR_CENTRE_Y:    arc_regs.centre_y    = words[i];
            eapm_pkg::CSR_CENTRE_Z:    arc_regs.centre_z    = words[i];
            eapm_pkg::CSR_START_TURNS: arc_regs.start_turns = words[i][23:0];
            eapm_pkg::CSR_END_TURNS:   arc_regs.stop_turns  = words[i][23:0];
            default:                   arc_regs.dims        = words[i][1:0];
         endcase
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly in range, with a share of clamped values above 1.0
   function automatic logic [eapm_pkg::PARAM_W-1:0] random_param();
      logic [eapm_pkg::PARAM_W-1:0] r;
      if ($urandom_range(99) < 85) begin
         r = eapm_pkg::PARAM_W'($urandom_range(0, 65536));
      end else begin
         r = eapm_pkg::PARAM_W'($urandom_range(0, 131071));
      end
      return r;
   endfunction

   // Q16.16: extremes, zero, full random, or a modest +/- 4.0
   function automatic logic [31:0] pick_coord();
      logic [31:0] raw;
      logic [31:0] v;
      raw = $urandom;
      case ($urandom_range(7))
         0:       v = 32'h7FFF_FFFF;
         1:       v = 32'h8000_0000;
         2:       v = 32'h0;
         3:       v = raw;
         default: v = {{13{raw[31]}}, raw[18:0]};
      endcase
      return v;
   endfunction

   // Q8.16 turns: extremes, junk above bit 23, or within +/- 2 turns
   function automatic logic [31:0] pick_turns();
      logic [31:0] raw;
      logic [31:0] v;
      raw = $urandom;
      case ($urandom_range(7))
         0:       v = 32'h0080_0000;
         1:       v = 32'h007F_FFFF;
         2:       v = raw;
         default: v = {{14{raw[31]}}, raw[17:0]};
      endcase
      return v;
   endfunction

   function automatic reg_words_type random_config();
      reg_words_type w;
      int            i;
      for (i = 0; i < 5; i++) w[i] = pick_coord();
      w[5] = pick_turns();
      w[6] = pick_turns();
      w[7] = $urandom;   // all four dims codes, upper bits ignored
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset registers: unit circle, one full turn. Ends of r, quadrant points, clamp.
   task automatic test_reset_defaults();
      send_param(17'd0);
      send_param(17'd1);
      send_param(17'd8192);
      send_param(17'd16384);
      send_param(17'd32768);
      send_param(17'd49152);
      send_param(17'd65535);
      send_param(17'd65536);
      send_param(17'd65537);
      send_param(17'h1FFFF);
   endtask

   // Register extremes: zero axes, saturation both ways, widest spans both signs,
   // dims codes 0, 1 and 3, and junk above the narrow registers.
   task automatic test_register_extremes();
      // zero axes act as 1.0; z on; start/end carry junk in the top byte
      apply_config('{32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF,
                     32'hA500_0000, 32'h5A01_0000, 32'hFFFF_FFFF});
      send_param(17'd0);
      send_param(17'd65536);
      send_param(17'd21845);
      // largest axes and centres, widest positive span, dims 0
      apply_config('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0000, 32'h0080_0000, 32'h007F_FFFF, 32'h0});
      send_param(17'd0);
      send_param(17'd65536);
      send_param(17'd65537);
      // mirrored extremes, widest negative span, dims 1
      apply_config('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h1234_5678, 32'h007F_FFFF, 32'h0080_0000, 32'h1});
      send_param(17'd0);
      send_param(17'h1FFFF);
      send_param(17'd40000);
      // start on an eighth-turn boundary, negative axis, z on
      apply_config('{32'hFFFE_0000, 32'h0003_0000, 32'h0001_8000, 32'hFFFF_4000,
                     32'hDEAD_BEEF, 32'h0000_2000, 32'h0000_E000, 32'h3});
      send_param(17'd0);
      send_param(17'd21845);
      send_param(17'd65536);
   endtask

   // Bulk random traffic across several random register settings
   task automatic test_random_stream();
      repeat (5) begin
         apply_config(random_config());
         repeat (120) send_param(random_param());
      end
   endtask

   // No idling on either side: one transaction per cycle
   task automatic test_back_to_back();
      apply_config(random_config());
      gap_pct = 0;
      repeat (100) send_param(random_param());
      gap_pct = IDLE_PCT;
   endtask

   // Receiver holds off while the sender keeps offering, so the pipe fills
   // and req_stall has to push back
   task automatic test_output_backpressure();
      gap_pct = 0;
      hold_ask <= hold_ask + 1;
      repeat (60) send_param(random_param());
      gap_pct = IDLE_PCT;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_register_extremes();
      test_random_stream();
      test_back_to_back();
      test_output_backpressure();

      // drain, then allow a pipeline's worth of cycles for stray responses
      wait_idle();
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
